### rtl/zud_pkg.sv
// Shared types, constants and elaboration-time helpers for the Zeckendorf counter.
// No dependencies; every other file of the block but zud_cmp_sub imports this package.
package zud_pkg;

    localparam int DIGITS_DEF  = 30;
    localparam int LOAD_W      = 22;
    localparam int VALUE_OUT_W = 22;
    localparam int ACTION_W    = 2;

    localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INC  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DEC  = 2'd2;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic capture;
        logic prep;
        logic step;
        logic publish;
    } zud_ctrl_t;

    // Weight of digit k, i.e. Fibonacci F(k+2); the digit below digit 0 weighs one.
    function automatic logic [63:0] fib_weight(input int k);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] t;
        a = 64'd1;
        b = 64'd1;
        for (int i = 0; i < k; i++) begin
            t = a + b;
            a = b;
            b = t;
        end
        return (k < 0) ? 64'd1 : b;
    endfunction

    // Width of the binary value: enough for the largest code, never below the load field.
    function automatic int val_width(input int digits);
        int w;
        w = $clog2(fib_weight(digits));
        return (w < LOAD_W) ? LOAD_W : w;
    endfunction

    // Result tdata: code, binary value and digit count, padded to whole bytes.
    function automatic int tdata_width(input int digits);
        int bits;
        bits = digits + VALUE_OUT_W + $clog2(digits + 1);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

### rtl/zeckendorf_up_down_counter.sv
// Top level of the Zeckendorf up/down counter: state, datapath and output register.
// Depends on zud_pkg, zud_ctrl and zud_cmp_sub.
//
//  channel | direction | tdata                 | tuser
//  s_      | in        | load_value            | action
//  m_      | out       | code, value, digits   | overflow, underflow
//
// Every transaction runs from acceptance through a prepare state, a convert state
// that walks the digits greedily through the shared compare-subtract unit, one
// digit per step, and a done state that hands the result to the output register.
// Input is ready again in the same cycle as the result appears; until then no new
// transaction is accepted.
// Reset clears the counter to zero and drops m_tvalid.
// A stalled result holds in the output register; the next transaction may be
// accepted meanwhile and waits at its end until the register is free.
module zeckendorf_up_down_counter #(
    parameter int  DIGITS = zud_pkg::DIGITS_DEF,
    localparam int CW     = $clog2(DIGITS + 1),
    localparam int TD_W   = zud_pkg::tdata_width(DIGITS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [zud_pkg::LOAD_W-1:0]    s_tdata,   // [21:0] load_value
    input  logic [zud_pkg::ACTION_W-1:0]  s_tuser,   // [1:0] action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TD_W-1:0]               m_tdata,   // zeck_code, binary_value, digit_count
    output logic [1:0]                    m_tuser    // [0] overflow_flag, [1] underflow_flag
);
    import zud_pkg::*;

    localparam int VW = val_width(DIGITS);
    localparam int KW = $clog2(DIGITS);
    localparam logic [VW-1:0] MAXV = VW'(fib_weight(DIGITS) - 64'd1);
    localparam logic [VW-1:0] WHI0 = VW'(fib_weight(DIGITS - 1));
    localparam logic [VW-1:0] WLO0 = VW'(fib_weight(DIGITS - 2));

    zud_ctrl_t     ctrl;
    logic [KW-1:0] digit_idx;
    logic          out_free;
    logic          take;
    logic [VW-1:0] diff;

    logic [ACTION_W-1:0] action_reg;
    logic [LOAD_W-1:0]   lv_reg;
    logic [VW-1:0]       value_reg, value_next;
    logic [DIGITS-1:0]   code_reg, code_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic                unf_reg, unf_next;
    logic [VW-1:0]       rem_reg, rem_next;
    logic [VW-1:0]       whi_reg, whi_next;
    logic [VW-1:0]       wlo_reg, wlo_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [TD_W-1:0]     m_tdata_reg;
    logic [1:0]          m_tuser_reg;
    logic [VW-1:0]       lv_wide;

    assign out_free = !m_tvalid_reg || m_tready;
    assign lv_wide  = VW'(lv_reg);

    zud_ctrl #(
        .DIGITS (DIGITS),
        .KW     (KW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .out_free  (out_free),
        .s_tready  (s_tready),
        .ctrl      (ctrl),
        .digit_idx (digit_idx)
    );

    zud_cmp_sub #(
        .VW (VW)
    ) u_unit (
        .remainder (rem_reg),
        .weight    (whi_reg),
        .take      (take),
        .diff      (diff)
    );

    always_comb begin
        value_next = value_reg;
        code_next  = code_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        unf_next   = unf_reg;
        rem_next   = rem_reg;
        whi_next   = whi_reg;
        wlo_next   = wlo_reg;
        if (ctrl.prep) begin
            ovf_next = 1'b0;
            unf_next = 1'b0;
            unique case (action_reg)
                ACT_LOAD: begin
                    if (lv_wide > MAXV) begin
                        value_next = MAXV;
                        ovf_next   = 1'b1;
                    end else begin
                        value_next = lv_wide;
                    end
                end
                ACT_INC: begin
                    if (value_reg >= MAXV) begin
                        ovf_next = 1'b1;
                    end else begin
                        value_next = value_reg + VW'(1);
                    end
                end
                ACT_DEC: begin
                    if (value_reg == '0) begin
                        unf_next = 1'b1;
                    end else begin
                        value_next = value_reg - VW'(1);
                    end
                end
                default: begin
                    value_next = value_reg;
                end
            endcase
            // The code is always rebuilt from the new value, which keeps it canonical.
            rem_next  = value_next;
            code_next = '0;
            cnt_next  = '0;
            whi_next  = WHI0;
            wlo_next  = WLO0;
        end else if (ctrl.step) begin
            if (take) begin
                rem_next             = diff;
                code_next[digit_idx] = 1'b1;
                if (cnt_reg == '0) begin
                    cnt_next = CW'(digit_idx) + CW'(1);
                end
            end
            // Step the weight pair one digit down.
            whi_next = wlo_reg;
            wlo_next = whi_reg - wlo_reg;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (ctrl.publish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg    <= '0;
            code_reg     <= '0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            unf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            value_reg    <= value_next;
            code_reg     <= code_next;
            cnt_reg      <= cnt_next;
            ovf_reg      <= ovf_next;
            unf_reg      <= unf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        whi_reg <= whi_next;
        wlo_reg <= wlo_next;
        if (ctrl.capture) begin
            action_reg <= s_tuser;
            lv_reg     <= s_tdata;
        end
        if (ctrl.publish) begin
            m_tdata_reg <= TD_W'({cnt_reg, value_reg[VALUE_OUT_W-1:0], code_reg});
            m_tuser_reg <= {unf_reg, ovf_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/zud_cmp_sub.sv
// Shared compare-and-subtract unit: tests one digit weight against the remainder.
// Depends on nothing but its width parameter.
module zud_cmp_sub #(
    parameter int VW = 22
) (
    input  logic [VW-1:0] remainder,
    input  logic [VW-1:0] weight,
    output logic          take,
    output logic [VW-1:0] diff
);

    assign take = (weight <= remainder);
    assign diff = remainder - weight;

endmodule

### rtl/zud_ctrl.sv
// Sequencer of the Zeckendorf counter: handshake, action preparation and digit walk.
// Depends on zud_pkg for the strobe struct.
module zud_ctrl #(
    parameter int DIGITS = zud_pkg::DIGITS_DEF,
    parameter int KW     = $clog2(DIGITS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                out_free,
    output logic                s_tready,
    output zud_pkg::zud_ctrl_t  ctrl,
    output logic [KW-1:0]       digit_idx
);
    import zud_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_CONV = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [KW-1:0] idx_reg, idx_next;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        ctrl         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_PREP;
                end
            end
            ST_PREP: begin
                ctrl.prep  = 1'b1;
                idx_next   = KW'(DIGITS - 1);
                state_next = ST_CONV;
            end
            ST_CONV: begin
                ctrl.step = 1'b1;
                idx_next  = idx_reg - KW'(1);
                if (idx_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    ctrl.publish = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign digit_idx = idx_reg;

endmodule

### rtl/zud_checker.sv
// Port-level checks for the Zeckendorf counter, bound to the top level.
// Depends on zud_pkg and zeckendorf_up_down_counter.
module zud_checker #(
    parameter int  DIGITS = zud_pkg::DIGITS_DEF,
    localparam int CW     = $clog2(DIGITS + 1),
    localparam int TD_W   = zud_pkg::tdata_width(DIGITS)
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [TD_W-1:0]               m_tdata,
    input logic [1:0]                    m_tuser
);
    import zud_pkg::*;

    localparam int CNT_LSB = DIGITS + VALUE_OUT_W;

    logic [DIGITS-1:0] code;
    logic [CW-1:0]     count;

    assign code  = m_tdata[DIGITS-1:0];
    assign count = m_tdata[CNT_LSB +: CW];

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The code is canonical and its digit count stays within range.
    a_canon: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((code & (code >> 1)) == '0) && (count <= CW'(DIGITS)))
        else $error("non-canonical code or digit count out of range");

    // Overflow and underflow never come together.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("both flags raised");

    // An accepted transaction keeps the input side busy in the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after a transaction");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind zeckendorf_up_down_counter zud_checker #(
    .DIGITS (DIGITS)
) u_zud_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
